@@ hdl/srts_pkg.sv @@
// Shared types, sizes and codes for the sorted record table with statistics.
package srts_pkg;

  localparam int DEPTH = 16;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int FLDW  = 16;
  localparam int TOTW  = FLDW + IDXW;
  localparam int DIVW  = TOTW + 8;
  localparam int DVSW  = CNTW + 1;
  localparam int ENTW  = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [FLDW-1:0] key;
    logic [FLDW-1:0] cnt;
    logic [FLDW-1:0] dur;
  } rec_t;

endpackage

@@ hdl/srts_store.sv @@
// Record memory: one write port, one registered read port.
module srts_store
  import srts_pkg::*;
(
  input  logic            clk,
  input  logic            we,
  input  logic [IDXW-1:0] waddr,
  input  rec_t            wdata,
  input  logic [IDXW-1:0] raddr,
  output rec_t            rdata
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/srts_div.sv @@
// Restoring divider, one quotient bit per cycle.
module srts_div
  import srts_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  input  logic [DVSW-1:0] divisor,
  output logic            done,
  output logic [DIVW-1:0] quotient
);

  localparam int STPW = $clog2(DIVW);

  logic            busy;
  logic [STPW-1:0] step;
  logic [DVSW-1:0] rem;
  logic [DVSW-1:0] dsr;
  logic [DIVW-1:0] quo;
  logic [DVSW:0]   trial;
  logic            qbit;
  logic [DVSW-1:0] rem_next;

  always_comb begin
    trial = {rem, quo[DIVW-1]};
    qbit  = (trial >= {1'b0, dsr});
    if (qbit) begin
      rem_next = DVSW'(trial - {1'b0, dsr});
    end else begin
      rem_next = DVSW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STPW'(DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath holds no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVW-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/sorted_record_table_stats.sv @@
// Top level: sorted record table with insert, delete and running statistics.
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result has been shown. Every transaction gives exactly one
// result, shown for a single cycle with done high; the receiver cannot stall
// it, so capture it on that cycle. The table lives in one record memory with
// one write port and a registered read port, and one shared serial divider
// produces both means. Work for one transaction, with n entries held after
// the operation and m entries moved: the moves (insert: m entries at or
// above the new key; delete: the scan up to the key plus the entries above
// it), then a minimum scan over the n entries, then the two divisions when n
// is not zero (DIVW = 28 at DEPTH 16). An operation that leaves the table
// empty skips the divisions. Statistics on an empty table read as zero
// with table_empty set. A rejected insert (table full) or delete (key
// missing) leaves the table unchanged and still reports statistics over it.
module sorted_record_table_stats
  import srts_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            opcode,
  input  logic [FLDW-1:0] record_key,
  input  logic [FLDW-1:0] item_count,
  input  logic [FLDW-1:0] item_duration,
  output logic            done,
  output logic [1:0]      status,
  output logic [ENTW-1:0] entries,
  output logic            table_empty,
  output logic [23:0]     mean_duration_q8,
  output logic [15:0]     mean_count,
  output logic [15:0]     min_duration
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS_RD  = 11'b000_0000_0010,
    S_INS_CHK = 11'b000_0000_0100,
    S_DEL_RD  = 11'b000_0000_1000,
    S_DEL_CHK = 11'b000_0001_0000,
    S_SHD_RD  = 11'b000_0010_0000,
    S_SHD_WR  = 11'b000_0100_0000,
    S_MIN_RD  = 11'b000_1000_0000,
    S_MIN_CHK = 11'b001_0000_0000,
    S_DIV_D   = 11'b010_0000_0000,
    S_DIV_C   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // Control registers
  logic [CNTW-1:0] fill;
  logic [TOTW-1:0] count_total;
  logic [TOTW-1:0] duration_total;

  // Working registers for the transaction in flight
  logic [CNTW-1:0] idx;
  rec_t            item;
  logic [1:0]      op_status;
  logic [FLDW-1:0] min_d;
  logic [23:0]     mean_d;

  // Memory and divider hookup
  logic            we;
  logic [IDXW-1:0] waddr;
  rec_t            wdata;
  logic [IDXW-1:0] raddr;
  rec_t            rdata;
  logic            div_start;
  logic [DIVW-1:0] div_dividend;
  logic [DVSW-1:0] div_divisor;
  logic            div_done;
  logic [DIVW-1:0] div_quo;

  logic            accept;
  logic            ins_shift;
  logic            stats_go;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Entry at idx-1 moves up while its key is not smaller than the new key.
  assign ins_shift = (rdata.key >= item.key);

  // Leaving the minimum scan with records held: kick off the first division.
  assign stats_go = (state == S_MIN_RD) && (idx == fill) && (fill != '0);

  srts_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  srts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Read address per state; shift-down reads one above, insert one below.
  always_comb begin
    unique case (state)
      S_INS_RD: raddr = IDXW'(idx - 1'b1);
      S_SHD_RD: raddr = IDXW'(idx + 1'b1);
      default:  raddr = idx[IDXW-1:0];
    endcase
  end

  // Write port: shifted entry or the new record.
  always_comb begin
    we    = 1'b0;
    waddr = idx[IDXW-1:0];
    wdata = item;
    unique case (state)
      S_INS_RD: begin
        we = (idx == '0);
      end
      S_INS_CHK: begin
        we = 1'b1;
        if (ins_shift) begin
          wdata = rdata;
        end
      end
      S_SHD_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Divider operands: duration mean first, then rounded count mean.
  always_comb begin
    div_start    = stats_go || ((state == S_DIV_D) && div_done);
    if (state == S_MIN_RD) begin
      div_dividend = {duration_total, 8'b0};
      div_divisor  = {1'b0, fill};
    end else begin
      div_dividend = DIVW'({count_total, 1'b0} + (TOTW + 1)'(fill));
      div_divisor  = {fill, 1'b0};
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_DELETE) begin
            state_next = S_DEL_RD;
          end else if (fill == CNTW'(DEPTH)) begin
            state_next = S_MIN_RD;
          end else begin
            state_next = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        state_next = (idx == '0) ? S_MIN_RD : S_INS_CHK;
      end
      S_INS_CHK: begin
        state_next = ins_shift ? S_INS_RD : S_MIN_RD;
      end
      S_DEL_RD: begin
        state_next = (idx == fill) ? S_MIN_RD : S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (rdata.key < item.key) begin
          state_next = S_DEL_RD;
        end else if (rdata.key == item.key) begin
          state_next = S_SHD_RD;
        end else begin
          state_next = S_MIN_RD;
        end
      end
      S_SHD_RD: begin
        state_next = ((idx + 1'b1) >= fill) ? S_MIN_RD : S_SHD_WR;
      end
      S_SHD_WR: begin
        state_next = S_SHD_RD;
      end
      S_MIN_RD: begin
        if (idx != fill) begin
          state_next = S_MIN_CHK;
        end else if (fill != '0) begin
          state_next = S_DIV_D;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MIN_CHK: begin
        state_next = S_MIN_RD;
      end
      S_DIV_D: begin
        if (div_done) begin
          state_next = S_DIV_C;
        end
      end
      S_DIV_C: begin
        if (div_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state: sequencer, fill level, running totals, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill           <= '0;
      count_total    <= '0;
      duration_total <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      // Strobe on an empty-table finish or when the count mean lands.
      done  <= ((state == S_MIN_RD) && (idx == fill) && (fill == '0)) ||
               ((state == S_DIV_C) && div_done);
      unique case (state)
        S_INS_RD: begin
          if (idx == '0) begin
            fill           <= fill + 1'b1;
            count_total    <= count_total + TOTW'(item.cnt);
            duration_total <= duration_total + TOTW'(item.dur);
          end
        end
        S_INS_CHK: begin
          if (!ins_shift) begin
            fill           <= fill + 1'b1;
            count_total    <= count_total + TOTW'(item.cnt);
            duration_total <= duration_total + TOTW'(item.dur);
          end
        end
        S_DEL_CHK: begin
          // Drop the matched record's share of the totals.
          if (rdata.key == item.key) begin
            count_total    <= count_total - TOTW'(rdata.cnt);
            duration_total <= duration_total - TOTW'(rdata.dur);
          end
        end
        S_SHD_RD: begin
          if ((idx + 1'b1) >= fill) begin
            fill <= fill - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item.key  <= record_key;
          item.cnt  <= item_count;
          item.dur  <= item_duration;
          if (opcode == OP_DELETE) begin
            op_status <= ST_DONE;
            idx       <= '0;
          end else if (fill == CNTW'(DEPTH)) begin
            op_status <= ST_FULL;
            idx       <= '0;
          end else begin
            op_status <= ST_DONE;
            idx       <= fill;
          end
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          idx <= '0;
        end
      end
      S_INS_CHK: begin
        // Advance down while shifting, then restart at the bottom for the scan.
        idx <= ins_shift ? idx - 1'b1 : '0;
      end
      S_DEL_RD: begin
        if (idx == fill) begin
          op_status <= ST_NOT_FOUND;
          idx       <= '0;
        end
      end
      S_DEL_CHK: begin
        if (rdata.key < item.key) begin
          idx <= idx + 1'b1;
        end else if (rdata.key != item.key) begin
          op_status <= ST_NOT_FOUND;
          idx       <= '0;
        end
      end
      S_SHD_RD: begin
        if ((idx + 1'b1) >= fill) begin
          idx <= '0;
        end
      end
      S_SHD_WR: begin
        idx <= idx + 1'b1;
      end
      S_MIN_RD: begin
        if ((idx == fill) && (fill == '0)) begin
          status           <= op_status;
          entries          <= ENTW'(fill);
          table_empty      <= 1'b1;
          mean_duration_q8 <= '0;
          mean_count       <= '0;
          min_duration     <= '0;
        end
      end
      S_MIN_CHK: begin
        if ((idx == '0) || (rdata.dur < min_d)) begin
          min_d <= rdata.dur;
        end
        idx <= idx + 1'b1;
      end
      S_DIV_D: begin
        if (div_done) begin
          mean_d <= div_quo[23:0];
        end
      end
      S_DIV_C: begin
        if (div_done) begin
          status           <= op_status;
          entries          <= ENTW'(fill);
          table_empty      <= 1'b0;
          mean_duration_q8 <= mean_d;
          mean_count       <= div_quo[15:0];
          min_duration     <= min_d;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNTW'(DEPTH))
    else $error("fill level beyond table depth");

  a_empty_totals: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> ((count_total == '0) && (duration_total == '0)))
    else $error("running totals nonzero on empty table");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (fill == CNTW'(DEPTH)))
    else $error("table-full status with room left");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (table_empty == (fill == '0)))
    else $error("table_empty disagrees with fill level");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE) && !$past(done))
    else $error("result strobe outside end of transaction");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> ((state == S_MIN_RD) || (state == S_DIV_D)))
    else $error("divider started outside statistics phase");

endmodule
